[rtl/tfwm_pkg.sv]
// Topic filter matcher: shared types and constants.
// Character codes, item/window/step structs and register map.
// No dependencies.
package tfwm_pkg;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    // APB register map: register i at byte address 4*i
    localparam int unsigned PADDR_W = 3;
    localparam logic [PADDR_W-1:2] REG_EXACT_ONLY = 1'b0;

    typedef struct packed {
        logic       mode;
        logic [7:0] char_code;
        logic       last;
    } item_t;

    // filter characters at pos, pos+1, pos+2
    typedef struct packed {
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
    } win_t;

    typedef struct packed {
        logic again;
        logic emit;
        logic matched;
    } step_t;

endpackage

[rtl/topic_filter_wildcard_match.sv]
// Topic filter matcher, top level: input register, match engine, filter store,
// result register and APB register port. Depends on tfwm_pkg, tfwm_store, tfwm_match.
//
// Load a filter with mode 0 characters (last on the final one), then stream a topic
// name with mode 1 characters; one matched transfer follows each name character with
// last set. One character per cycle unless a stalled result holds a name's last one;
// a taken transfer sits in the input register, a name's result in the output register.
// The other exception is a '/' in the name meeting a '+' in the filter (an empty
// level): it holds the input register while the engine steps one filter position per
// cycle past each '+'. The filter lives in three MAX_FILTER_LEN x 8 RAMs with a
// registered read port; longer filters are truncated. exact_only (address 0) turns the
// '+' and '#' wildcards off; the user writes it only while no name is in flight.
module topic_filter_wildcard_match #(
    parameter int unsigned MAX_FILTER_LEN = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic                              mode,
    input  logic [7:0]                        char_code,
    input  logic                              last,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic                              matched,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tfwm_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import tfwm_pkg::*;

    localparam int unsigned LW = $clog2(MAX_FILTER_LEN + 1);

    logic          item_valid_reg;
    item_t         item_reg;
    logic          result_valid_reg;
    logic          matched_reg;
    logic          exact_only_reg;

    logic          out_space, fire, done, accept;
    step_t         step;
    win_t          window;
    logic [LW-1:0] rd_pos, wr_pos;
    logic          wr_en;
    logic [7:0]    wr_char;

    assign out_space  = !result_valid_reg || !result_stall;
    assign fire       = item_valid_reg && (!(item_reg.mode && item_reg.last) || out_space);
    assign done       = fire && !step.again;
    assign item_stall = item_valid_reg && !done;
    assign accept     = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (done)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.mode      <= mode;
            item_reg.char_code <= char_code;
            item_reg.last      <= last;
        end
        if (step.emit)
        begin
            matched_reg <= step.matched;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (step.emit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exact_only_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && paddr[PADDR_W-1:2] == REG_EXACT_ONLY)
        begin
            exact_only_reg <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1:2] == REG_EXACT_ONLY) ? {31'd0, exact_only_reg} : 32'd0;

    tfwm_match #(
        .MAX_FILTER_LEN (MAX_FILTER_LEN)
    ) u_match (
        .clk        (clk),
        .rst_n      (rst_n),
        .exact_only (exact_only_reg),
        .fire       (fire),
        .item       (item_reg),
        .window     (window),
        .rd_pos     (rd_pos),
        .wr_en      (wr_en),
        .wr_pos     (wr_pos),
        .wr_char    (wr_char),
        .step       (step)
    );

    tfwm_store #(
        .MAX_FILTER_LEN (MAX_FILTER_LEN)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_pos  (wr_pos),
        .wr_char (wr_char),
        .rd_pos  (rd_pos),
        .window  (window)
    );

    assign result_valid = result_valid_reg;
    assign matched      = matched_reg;

endmodule

[rtl/tfwm_store.sv]
// Topic filter store: three simple dual-port RAMs holding the filter at offsets 0, 1, 2
// so one read address returns a three-character window. Registered read, write bypass.
// Depends on tfwm_pkg.
module tfwm_store #(
    parameter int unsigned MAX_FILTER_LEN = 256
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [$clog2(MAX_FILTER_LEN+1)-1:0]   wr_pos,
    input  logic [7:0]                            wr_char,
    input  logic [$clog2(MAX_FILTER_LEN+1)-1:0]   rd_pos,
    output tfwm_pkg::win_t                        window
);
    import tfwm_pkg::*;

    localparam int unsigned LW = $clog2(MAX_FILTER_LEN + 1);
    localparam int unsigned AW = $clog2(MAX_FILTER_LEN);

    logic [7:0] mem0 [MAX_FILTER_LEN];
    logic [7:0] mem1 [MAX_FILTER_LEN];
    logic [7:0] mem2 [MAX_FILTER_LEN];

    logic          we0, we1, we2;
    logic [LW-1:0] pos_m1, pos_m2;
    logic [AW-1:0] wa0, wa1, wa2, ra;
    win_t          window_reg;

    assign pos_m1 = wr_pos - LW'(1);
    assign pos_m2 = wr_pos - LW'(2);
    assign we0    = wr_en;
    assign we1    = wr_en && (wr_pos >= LW'(1));
    assign we2    = wr_en && (wr_pos >= LW'(2));
    assign wa0    = wr_pos[AW-1:0];
    assign wa1    = pos_m1[AW-1:0];
    assign wa2    = pos_m2[AW-1:0];
    assign ra     = rd_pos[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (we0)
        begin
            mem0[wa0] <= wr_char;
        end
        if (we1)
        begin
            mem1[wa1] <= wr_char;
        end
        if (we2)
        begin
            mem2[wa2] <= wr_char;
        end
        window_reg.c0 <= (we0 && wa0 == ra) ? wr_char : mem0[ra];
        window_reg.c1 <= (we1 && wa1 == ra) ? wr_char : mem1[ra];
        window_reg.c2 <= (we2 && wa2 == ra) ? wr_char : mem2[ra];
    end

    assign window = window_reg;

endmodule

[rtl/tfwm_match.sv]
// Topic filter match engine: filter load pointer, length and per-name match state.
// One character step per fired cycle on the store window; drives store read/write.
// Depends on tfwm_pkg.
module tfwm_match #(
    parameter int unsigned MAX_FILTER_LEN = 256
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  exact_only,
    input  logic                                  fire,
    input  tfwm_pkg::item_t                       item,
    input  tfwm_pkg::win_t                        window,
    output logic [$clog2(MAX_FILTER_LEN+1)-1:0]   rd_pos,
    output logic                                  wr_en,
    output logic [$clog2(MAX_FILTER_LEN+1)-1:0]   wr_pos,
    output logic [7:0]                            wr_char,
    output tfwm_pkg::step_t                       step
);
    import tfwm_pkg::*;

    localparam int unsigned LW = $clog2(MAX_FILTER_LEN + 1);
    localparam int unsigned EW = LW + 2;

    logic [LW-1:0] pos_reg, pos_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] load_reg, load_next;
    logic          skip_reg, skip_next;
    logic          decided_reg, decided_next;
    logic          value_reg, value_next;

    logic          at_end, hit, tail_hash, tail_plus;
    logic [EW-1:0] pos_ext, len_ext;

    assign pos_ext = {2'b00, pos_reg};
    assign len_ext = {2'b00, len_reg};
    assign at_end  = (pos_reg >= len_reg);
    assign hit     = (window.c0 == item.char_code);
    // filter ends in "/#" right after this character, or in '+' right after it
    assign tail_hash = item.last && (pos_ext + EW'(3) == len_ext)
                       && (window.c1 == CH_SLASH) && (window.c2 == CH_HASH);
    assign tail_plus = item.last && (pos_ext + EW'(2) == len_ext)
                       && (window.c1 == CH_PLUS);

    always_comb
    begin
        pos_next     = pos_reg;
        len_next     = len_reg;
        load_next    = load_reg;
        skip_next    = skip_reg;
        decided_next = decided_reg;
        value_next   = value_reg;
        wr_en        = 1'b0;
        step         = '0;
        if (fire)
        begin
            if (!item.mode)
            begin
                // filter character: abandon any name in progress
                pos_next     = '0;
                skip_next    = 1'b0;
                decided_next = 1'b0;
                value_next   = 1'b0;
                if (load_reg < LW'(MAX_FILTER_LEN))
                begin
                    wr_en     = 1'b1;
                    load_next = load_reg + LW'(1);
                end
                if (item.last)
                begin
                    len_next  = load_next;
                    load_next = '0;
                end
            end
            else
            begin
                if (!decided_reg)
                begin
                    if (exact_only)
                    begin
                        if (at_end || !hit)
                        begin
                            decided_next = 1'b1;
                            value_next   = 1'b0;
                        end
                        else
                        begin
                            pos_next = pos_reg + LW'(1);
                        end
                    end
                    else if (skip_reg && item.char_code != CH_SLASH)
                    begin
                        // still inside a level taken by '+'
                        skip_next = 1'b1;
                    end
                    else
                    begin
                        skip_next = 1'b0;
                        if (at_end)
                        begin
                            decided_next = 1'b1;
                            value_next   = 1'b0;
                        end
                        else if (hit)
                        begin
                            if (tail_hash || tail_plus)
                            begin
                                decided_next = 1'b1;
                                value_next   = 1'b1;
                            end
                            else
                            begin
                                pos_next = pos_reg + LW'(1);
                            end
                        end
                        else if (window.c0 == CH_PLUS)
                        begin
                            pos_next = pos_reg + LW'(1);
                            if (item.char_code != CH_SLASH)
                            begin
                                skip_next = 1'b1;
                            end
                            else
                            begin
                                // empty level: retry '/' on the next filter char
                                step.again = 1'b1;
                            end
                        end
                        else
                        begin
                            decided_next = 1'b1;
                            value_next   = (window.c0 == CH_HASH);
                        end
                    end
                end
                if (item.last && !step.again)
                begin
                    step.emit    = 1'b1;
                    step.matched = decided_next ? value_next : (pos_next == len_reg);
                    pos_next     = '0;
                    skip_next    = 1'b0;
                    decided_next = 1'b0;
                    value_next   = 1'b0;
                end
            end
        end
    end

    assign rd_pos  = pos_next;
    assign wr_pos  = load_reg;
    assign wr_char = item.char_code;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            len_reg     <= '0;
            load_reg    <= '0;
            skip_reg    <= 1'b0;
            decided_reg <= 1'b0;
            value_reg   <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            load_reg    <= load_next;
            skip_reg    <= skip_next;
            decided_reg <= decided_next;
            value_reg   <= value_next;
        end
    end

endmodule

[rtl/tfwm_checker.sv]
// Port-level checker for the topic filter matcher, bound to the top level.
// Depends on tfwm_pkg and topic_filter_wildcard_match.
module tfwm_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         item_valid,
    input logic                         item_stall,
    input logic                         mode,
    input logic                         last,
    input logic                         result_valid,
    input logic                         result_stall,
    input logic                         matched,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic [tfwm_pkg::PADDR_W-1:0] paddr,
    input logic [31:0]                  pwdata,
    input logic [31:0]                  prdata,
    input logic                         pready
);
    import tfwm_pkg::*;

    logic [1:0] pend_reg, pend_next;
    logic       name_end, result_xfer, reg_wr, reg_rd;

    assign name_end    = item_valid && !item_stall && mode && last;
    assign result_xfer = result_valid && !result_stall;
    assign reg_wr      = psel && penable && pwrite && pready
                         && paddr[PADDR_W-1:2] == REG_EXACT_ONLY;
    assign reg_rd      = psel && !pwrite && paddr[PADDR_W-1:2] == REG_EXACT_ONLY;
    assign pend_next   = pend_reg + {1'b0, name_end} - {1'b0, result_xfer};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(matched))
        else $error("result changed while stalled");

    a_idle_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !item_valid && !item_stall |=> !item_stall)
        else $error("input stalled with nothing in flight");

    a_result_has_name: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pend_reg != 2'd0)
        else $error("result without a finished name");

    a_reg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && $past(reg_wr) && reg_rd |-> prdata[0] == $past(pwdata[0]))
        else $error("exact_only readback mismatch");

endmodule

bind topic_filter_wildcard_match tfwm_checker u_tfwm_checker (.*);

[sim/tb_topic_filter_wildcard_match.sv]
// Self-checking testbench for topic_filter_wildcard_match: loads filters, streams topic names
// and compares each match bit against an in-bench predictor of the matcher.
// Depends on tfwm_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb_topic_filter_wildcard_match;
    import tfwm_pkg::*;

    localparam int unsigned MAX_FILTER_LEN = 256;
    localparam int unsigned DRAIN_CYCLES   = MAX_FILTER_LEN + 40;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    logic        mode;
    logic [7:0]  char_code;
    logic        last;
    logic        result_valid;
    logic        result_stall;
    logic        matched;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    topic_filter_wildcard_match #(
        .MAX_FILTER_LEN(MAX_FILTER_LEN)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .mode        (mode),
        .char_code   (char_code),
        .last        (last),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .matched     (matched),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    item_t       pending_chars[$];
    logic        expected_matches[$];
    logic [7:0]  flt_text[$];
    logic [7:0]  name_text[$];
    int unsigned n_queued;
    int unsigned n_sent;
    int unsigned n_accepted;
    int unsigned send_idle;
    int unsigned recv_idle;
    int unsigned errors;

    // predictor state
    logic [7:0]  flt_mem[MAX_FILTER_LEN];
    int unsigned flt_len;
    int unsigned load_ptr;
    int unsigned flt_ptr;
    bit          skip_level;
    bit          is_decided;
    bit          held_match;
    bit          exact_mode;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic void settle(bit v);
        is_decided = 1'b1;
        held_match = v;
    endfunction

    function automatic void clear_name();
        flt_ptr    = 0;
        skip_level = 1'b0;
        is_decided = 1'b0;
        held_match = 1'b0;
    endfunction

    function automatic void wild_step(logic [7:0] c, bit is_last);
        int unsigned fi;
        bit          done;
        done = 1'b0;
        if (skip_level) begin
            if (c != CH_SLASH)
                return;
            skip_level = 1'b0;
        end
        while (!done) begin
            fi   = flt_ptr;
            done = 1'b1;
            if (fi >= flt_len)
                settle(1'b0);
            else if (c == flt_mem[fi]) begin
                if (is_last && fi + 3 == flt_len && flt_mem[fi+1] == CH_SLASH
                    && flt_mem[fi+2] == CH_HASH)
                    settle(1'b1);
                else if (is_last && fi + 2 == flt_len && flt_mem[fi+1] == CH_PLUS)
                    settle(1'b1);
                else
                    flt_ptr = fi + 1;
            end
            else if (flt_mem[fi] == CH_PLUS) begin
                flt_ptr = fi + 1;
                if (c != CH_SLASH)
                    skip_level = 1'b1;
                else
                    done = 1'b0;
            end
            else
                settle(flt_mem[fi] == CH_HASH);
        end
    endfunction

    function automatic void advance_matcher(logic m, logic [7:0] c, logic l);
        if (!m) begin
            clear_name();
            if (load_ptr < MAX_FILTER_LEN) begin
                flt_mem[load_ptr] = c;
                load_ptr++;
            end
            if (l) begin
                flt_len  = load_ptr;
                load_ptr = 0;
            end
            return;
        end
        if (!is_decided) begin
            if (exact_mode) begin
                if (flt_ptr >= flt_len || flt_mem[flt_ptr] != c)
                    settle(1'b0);
                else
                    flt_ptr++;
            end
            else
                wild_step(c, l);
        end
        if (l) begin
            expected_matches.push_back(is_decided ? held_match : (flt_ptr == flt_len));
            clear_name();
        end
    endfunction

    // sender: present the next character once the previous one has been accepted
    always @(negedge clk) begin : sender
        item_t it;
        if (rst_n && n_accepted == n_sent) begin
            if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle) begin
                it = pending_chars.pop_front();
                n_sent++;
                item_valid <= 1'b1;
                mode       <= it.mode;
                char_code  <= it.char_code;
                last       <= it.last;
            end
            else
                item_valid <= 1'b0;
        end
        result_stall <= rst_n && ($urandom_range(99) < recv_idle);
    end

    always @(posedge clk) begin
        if (rst_n && item_valid && !item_stall) begin
            advance_matcher(mode, char_code, last);
            n_accepted++;
        end
    end

    always @(posedge clk) begin : result_check
        logic want;
        if (rst_n && result_valid && !result_stall) begin
            if (expected_matches.size() == 0) begin
                $error("matched: expected no transfer, actual %0b", matched);
                errors++;
            end
            else begin
                want = expected_matches.pop_front();
                if (matched !== want) begin
                    $error("matched: expected %0b, actual %0b", want, matched);
                    errors++;
                end
            end
        end
    end

    function automatic void push_char(logic m, logic [7:0] c, logic l);
        item_t it;
        it.mode      = m;
        it.char_code = c;
        it.last      = l;
        pending_chars.push_back(it);
        n_queued++;
    endfunction

    function automatic void send_text(bit m);
        int unsigned n;
        n = m ? name_text.size() : flt_text.size();
        for (int unsigned i = 0; i < n; i++)
            push_char(m, m ? name_text[i] : flt_text[i], i == n - 1);
    endfunction

    function automatic logic [7:0] rand_letter();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40)
            return "a";
        if (r < 75)
            return "b";
        if (r < 88)
            return "c";
        return 8'($urandom_range(255));
    endfunction

    function automatic void build_filter();
        int unsigned nlev;
        int unsigned r;
        flt_text.delete();
        nlev = $urandom_range(1, 4);
        for (int unsigned lv = 0; lv < nlev; lv++) begin
            if (lv > 0)
                flt_text.push_back(CH_SLASH);
            r = $urandom_range(99);
            if (r < 22) begin
                flt_text.push_back(CH_PLUS);
                if ($urandom_range(99) < 20)
                    flt_text.push_back(CH_PLUS);
            end
            else if (r < 34 && lv == nlev - 1)
                flt_text.push_back(CH_HASH);
            else
                repeat ($urandom_range(1, 2)) flt_text.push_back(rand_letter());
        end
    endfunction

    // name built to follow the current filter, then sometimes damaged
    function automatic void build_name(bit exact);
        logic [7:0] c;
        name_text.delete();
        if (exact && $urandom_range(99) < 60)
            name_text = flt_text;
        else begin
            foreach (flt_text[i]) begin
                c = flt_text[i];
                if (c == CH_PLUS)
                    repeat ($urandom_range(0, 2)) name_text.push_back(rand_letter());
                else if (c == CH_HASH) begin
                    if ($urandom_range(99) < 30 && name_text.size() > 0
                        && name_text[$] == CH_SLASH)
                        void'(name_text.pop_back());
                    else
                        repeat ($urandom_range(0, 4))
                            name_text.push_back($urandom_range(99) < 30 ? CH_SLASH
                                                                       : rand_letter());
                end
                else
                    name_text.push_back(c);
            end
        end
        if ($urandom_range(99) < 20 && name_text.size() > 0)
            name_text[$urandom_range(name_text.size() - 1)] = rand_letter();
        if ($urandom_range(99) < 10)
            name_text.push_back(rand_letter());
        if (name_text.size() == 0)
            name_text.push_back("a");
    endfunction

    function automatic void queue_unit(bit exact);
        int unsigned r;
        int unsigned k;
        int unsigned n;
        r = $urandom_range(99);
        if (r < 12) begin
            build_filter();
            send_text(0);
        end
        else if (r < 16) begin
            // name cut short by a filter load
            n = $urandom_range(1, 3);
            repeat (n) push_char(1'b1, rand_letter(), 1'b0);
            build_filter();
            send_text(0);
        end
        else if (r < 20) begin
            // name against a half-loaded filter
            build_filter();
            k = flt_text.size() / 2;
            for (int unsigned i = 0; i < k; i++)
                push_char(1'b0, flt_text[i], 1'b0);
            push_char(1'b1, rand_letter(), 1'b1);
            for (int unsigned i = k; i < flt_text.size(); i++)
                push_char(1'b0, flt_text[i], i == flt_text.size() - 1);
        end
        else if (r < 28) begin
            n = $urandom_range(1, 4);
            for (int unsigned i = 0; i < n; i++)
                push_char(1'b1, 8'($urandom_range(255)), i == n - 1);
        end
        else begin
            build_name(exact);
            send_text(1);
        end
    endfunction

    function automatic void queue_random(int unsigned target, bit exact);
        int unsigned start;
        start = n_queued;
        build_filter();
        send_text(0);
        while (n_queued - start < target)
            queue_unit(exact);
    endfunction

    // filter past the store size, a name equal to the part that fits, then that name plus one
    function automatic void queue_long_filter();
        flt_text.delete();
        repeat (MAX_FILTER_LEN + $urandom_range(1, 4)) flt_text.push_back(rand_letter());
        send_text(0);
        name_text = flt_text[0:MAX_FILTER_LEN-1];
        send_text(1);
        name_text.push_back("a");
        send_text(1);
    endfunction

    task automatic wait_idle();
        while (n_accepted != n_queued)
            @(posedge clk);
        while (expected_matches.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_exact(bit v);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_EXACT_ONLY, 2'b00};
        pwdata  <= {31'b0, v};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        exact_mode = v;
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {31'b0, v}) begin
            $error("exact_only: expected %0h, actual %0h", {31'b0, v}, prdata);
            errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        mode         = 1'b0;
        char_code    = 8'h00;
        last         = 1'b0;
        result_stall = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        n_queued     = 0;
        n_sent       = 0;
        n_accepted   = 0;
        errors       = 0;
        send_idle    = 6;
        recv_idle    = 53;
        flt_len      = 0;
        load_ptr     = 0;
        exact_mode   = 1'b0;
        clear_name();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_exact(1'b0);

        // empty filter never matches
        push_char(1'b1, "x", 1'b1);
        // a/#: parent level, then hash takes the rest
        push_char(1'b0, "a", 1'b0);
        push_char(1'b0, CH_SLASH, 1'b0);
        push_char(1'b0, CH_HASH, 1'b1);
        push_char(1'b1, "a", 1'b1);
        push_char(1'b1, "a", 1'b0);
        push_char(1'b1, CH_SLASH, 1'b0);
        push_char(1'b1, 8'hFF, 1'b1);
        // repeated plus against empty levels
        push_char(1'b0, CH_PLUS, 1'b0);
        push_char(1'b0, CH_PLUS, 1'b0);
        push_char(1'b0, CH_SLASH, 1'b1);
        push_char(1'b1, CH_SLASH, 1'b1);
        // name dropped by a filter load
        push_char(1'b1, "b", 1'b0);
        push_char(1'b0, CH_PLUS, 1'b1);
        push_char(1'b1, 8'h00, 1'b1);
        // name between two halves of a filter
        push_char(1'b0, "z", 1'b0);
        push_char(1'b1, 8'hFF, 1'b1);
        push_char(1'b0, CH_SLASH, 1'b1);
        // early mismatch, rest ignored
        push_char(1'b1, "q", 1'b0);
        push_char(1'b1, "r", 1'b1);
        // trailing plus matches an empty last level
        push_char(1'b0, "a", 1'b0);
        push_char(1'b0, CH_SLASH, 1'b0);
        push_char(1'b0, CH_PLUS, 1'b1);
        push_char(1'b1, "a", 1'b0);
        push_char(1'b1, CH_SLASH, 1'b1);

        queue_random(540, 1'b0);
        wait_idle();

        send_idle = 53;
        recv_idle = 6;
        write_exact(1'b1);
        queue_random(540, 1'b1);
        wait_idle();

        send_idle = 0;
        recv_idle = 0;
        write_exact(1'b0);
        queue_long_filter();
        queue_random(80, 1'b0);
        wait_idle();

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
rtl/tfwm_pkg.sv
rtl/tfwm_store.sv
rtl/tfwm_match.sv
rtl/topic_filter_wildcard_match.sv
rtl/tfwm_checker.sv
sim/tb_topic_filter_wildcard_match.sv
